### design/sstq_pkg.sv
// Shared types and constants for the stable sorted time queue.
// No dependencies; used by sstq_cell and stable_sorted_time_queue_unit.
package sstq_pkg;

  localparam int DEPTH       = 16;
  localparam int TIME_BITS   = 32;
  localparam int HANDLE_BITS = 8;
  localparam int OCC_BITS    = $clog2(DEPTH + 1);
  localparam int STATUS_BITS = 2;

  // stream payload widths, padded to whole bytes
  localparam int IN_FIELD_W  = TIME_BITS + HANDLE_BITS;
  localparam int IN_DATA_W   = ((IN_FIELD_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = STATUS_BITS + 2 * (TIME_BITS + HANDLE_BITS) + OCC_BITS;
  localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    OP_HOLD,
    OP_PUSH,
    OP_POP
  } op_t;

  // broadcast to every cell in the chain
  typedef struct packed {
    op_t                    op;
    logic [TIME_BITS-1:0]   key;
    logic [HANDLE_BITS-1:0] handle;
  } cell_ctrl_t;

endpackage

### design/sstq_cell.sv
// One slot of the sorted chain: holds a time/handle pair and shifts toward
// its neighbors on push or pop. Depends on sstq_pkg.
module sstq_cell (
  input  logic                             clk,
  input  sstq_pkg::cell_ctrl_t             ctrl,
  input  logic                             slot_valid,  // slot index below occupancy
  input  logic                             left_keep,   // left neighbor stays in place
  input  logic [sstq_pkg::TIME_BITS-1:0]   left_time,
  input  logic [sstq_pkg::HANDLE_BITS-1:0] left_handle,
  input  logic [sstq_pkg::TIME_BITS-1:0]   right_time,
  input  logic [sstq_pkg::HANDLE_BITS-1:0] right_handle,
  output logic                             keep,
  output logic [sstq_pkg::TIME_BITS-1:0]   time_q,
  output logic [sstq_pkg::HANDLE_BITS-1:0] handle_q,
  output logic [sstq_pkg::TIME_BITS-1:0]   time_nxt,
  output logic [sstq_pkg::HANDLE_BITS-1:0] handle_nxt
);

  logic [sstq_pkg::TIME_BITS-1:0]   time_r;
  logic [sstq_pkg::HANDLE_BITS-1:0] handle_r;

  // equal keys stay ahead of the new entry, which keeps arrival order
  assign keep = slot_valid && (time_r <= ctrl.key);

  always_comb begin
    time_nxt   = time_r;
    handle_nxt = handle_r;
    case (ctrl.op)
      sstq_pkg::OP_PUSH: begin
        if (!left_keep) begin
          time_nxt   = left_time;
          handle_nxt = left_handle;
        end else if (!keep) begin
          time_nxt   = ctrl.key;
          handle_nxt = ctrl.handle;
        end
      end
      sstq_pkg::OP_POP: begin
        time_nxt   = right_time;
        handle_nxt = right_handle;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    time_r   <= time_nxt;
    handle_r <= handle_nxt;
  end

  assign time_q   = time_r;
  assign handle_q = handle_r;

endmodule

### design/stable_sorted_time_queue_unit.sv
// Top level of the stable sorted time queue: a chain of sstq_cell slots,
// occupancy counter and registered result beat. Depends on sstq_pkg, sstq_cell.
//
// Usage:
//   Input beats (in_*) carry a push (in_tuser = 0) with a time and a handle,
//   or a pop (in_tuser = 1). Every accepted beat yields exactly one result
//   beat (out_*) with status, the popped entry (zero unless a pop succeeded),
//   the head entry after the step (zero when empty) and the occupancy.
//   A push lands behind every entry with an equal or earlier time, so equal
//   times leave in arrival order. Push on full is dropped (status full);
//   pop on empty changes nothing (status empty).
// Timing and throughput:
//   The whole chain of cells compares against the broadcast key and all cells
//   shift on the same clock edge; the result appears in the output register
//   on the cycle after acceptance. One beat per cycle is sustained while
//   out_tready stays high.
// Reset and stall:
//   rst_n (synchronous, active low) empties the queue and drops any pending
//   result. While the receiver holds out_tready low with a result waiting,
//   in_tready is low and the queue state holds.
module stable_sorted_time_queue_unit (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [sstq_pkg::IN_DATA_W-1:0]  in_tdata,   // insert_time, insert_handle
  input  logic [0:0]                      in_tuser,   // mode
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [sstq_pkg::OUT_DATA_W-1:0] out_tdata   // status, popped_time,
                                                      // popped_handle, head_time,
                                                      // head_handle, occupancy
);

  localparam int TB = sstq_pkg::TIME_BITS;
  localparam int HB = sstq_pkg::HANDLE_BITS;
  localparam int OB = sstq_pkg::OCC_BITS;
  localparam int N  = sstq_pkg::DEPTH;

  logic                  in_fire;
  logic [OB-1:0]         count_r, count_nxt;
  logic                  out_valid_r, out_valid_nxt;
  logic [sstq_pkg::OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  sstq_pkg::cell_ctrl_t  ctrl;
  sstq_pkg::status_t     status;
  logic                  is_pop;
  logic                  is_full, is_empty;

  logic [N-1:0]          slot_valid;
  logic [N:0]            keep_chain;
  logic [TB-1:0]         time_q   [N];
  logic [HB-1:0]         handle_q [N];
  logic [TB-1:0]         time_nxt [N];
  logic [HB-1:0]         handle_nxt [N];

  logic [TB-1:0]         popped_time;
  logic [HB-1:0]         popped_handle;
  logic [TB-1:0]         head_time;
  logic [HB-1:0]         head_handle;

  assign in_tready = !out_valid_r || out_tready;
  assign in_fire   = in_tvalid && in_tready;
  assign is_pop    = in_tuser[0];
  assign is_full   = (count_r == OB'(N));
  assign is_empty  = (count_r == '0);

  always_comb begin
    ctrl.key    = in_tdata[TB-1:0];
    ctrl.handle = in_tdata[TB +: HB];
    ctrl.op     = sstq_pkg::OP_HOLD;
    status      = sstq_pkg::ST_OK;
    count_nxt   = count_r;
    if (in_fire) begin
      if (!is_pop) begin
        if (is_full) begin
          status = sstq_pkg::ST_FULL;
        end else begin
          ctrl.op   = sstq_pkg::OP_PUSH;
          count_nxt = count_r + OB'(1);
        end
      end else begin
        if (is_empty) begin
          status = sstq_pkg::ST_EMPTY;
        end else begin
          ctrl.op   = sstq_pkg::OP_POP;
          count_nxt = count_r - OB'(1);
        end
      end
    end
  end

  // the head slot has nothing ahead of it, so it always sees a keeping left
  assign keep_chain[0] = 1'b1;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign slot_valid[i] = (OB'(i) < count_r);

    sstq_cell u_cell (
      .clk          (clk),
      .ctrl         (ctrl),
      .slot_valid   (slot_valid[i]),
      .left_keep    (keep_chain[i]),
      .left_time    ((i == 0) ? time_q[0]   : time_q[(i == 0) ? 0 : i-1]),
      .left_handle  ((i == 0) ? handle_q[0] : handle_q[(i == 0) ? 0 : i-1]),
      .right_time   (time_q[(i == N-1) ? i : i+1]),
      .right_handle (handle_q[(i == N-1) ? i : i+1]),
      .keep         (keep_chain[i+1]),
      .time_q       (time_q[i]),
      .handle_q     (handle_q[i]),
      .time_nxt     (time_nxt[i]),
      .handle_nxt   (handle_nxt[i])
    );
  end

  always_comb begin
    popped_time   = '0;
    popped_handle = '0;
    if (ctrl.op == sstq_pkg::OP_POP) begin
      popped_time   = time_q[0];
      popped_handle = handle_q[0];
    end
    head_time   = '0;
    head_handle = '0;
    if (count_nxt != '0) begin
      head_time   = time_nxt[0];
      head_handle = handle_nxt[0];
    end
  end

  always_comb begin
    out_data_nxt = out_data_r;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      out_valid_nxt = 1'b1;
      out_data_nxt  = '0;
      out_data_nxt[sstq_pkg::STATUS_BITS-1:0]                  = status;
      out_data_nxt[sstq_pkg::STATUS_BITS +: TB]                = popped_time;
      out_data_nxt[sstq_pkg::STATUS_BITS + TB +: HB]           = popped_handle;
      out_data_nxt[sstq_pkg::STATUS_BITS + TB + HB +: TB]      = head_time;
      out_data_nxt[sstq_pkg::STATUS_BITS + 2*TB + HB +: HB]    = head_handle;
      out_data_nxt[sstq_pkg::STATUS_BITS + 2*TB + 2*HB +: OB]  = count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
